// ----- rtl/core/soas_pkg.sv -----
// ----------------------------------------------------------------------------
// soas_pkg
// Shared types, constants and the microcode table of the actuator step unit.
// ----------------------------------------------------------------------------
package soas_pkg;

	localparam int unsigned STATE_W   = 48;
	localparam int unsigned MAG_W     = STATE_W + 1;
	localparam int unsigned COEF_W    = 31;
	localparam int unsigned TS_W      = 24;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned MUL_A_W   = 32;
	localparam int unsigned PRD_W     = MUL_A_W + COEF_W;
	localparam int unsigned ACC_W     = MAG_W + COEF_W;
	localparam int unsigned STEP_W    = 5;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [STATE_W-1:0] MAX48_MAG = 48'h7FFF_FFFF_FFFF;
	localparam logic [STATE_W-1:0] MIN48_MAG = 48'h8000_0000_0000;

	localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
	localparam logic [STEP_W-1:0] STEP_LAST  = 5'd21;

	localparam logic [CFG_IDX_W-1:0] CFG_DEFL_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WN_SQUARED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd4;

	localparam logic [COEF_W-1:0] RST_DEFL_LIMIT = 31'd655360;
	localparam logic [COEF_W-1:0] RST_RATE_LIMIT = 31'd1638400;
	localparam logic [COEF_W-1:0] RST_WN_SQUARED = 31'd2151403;
	localparam logic [COEF_W-1:0] RST_DAMPING    = 31'd600793;
	localparam logic [TS_W-1:0]   RST_TIME_STEP  = 24'd16777;

	typedef struct packed {
		logic [COEF_W-1:0] deflection_limit;
		logic [COEF_W-1:0] rate_limit;
		logic [COEF_W-1:0] wn_squared;
		logic [COEF_W-1:0] damping_coeff;
		logic [TS_W-1:0]   time_step;
	} cfg_t;

	typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
	typedef enum logic [2:0] {LD_NONE, LD_LIM, LD_RSUM, LD_ERR, LD_ASUM} ld_t;
	typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_t;
	typedef enum logic [1:0] {COEF_TS, COEF_WN, COEF_DC} coef_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADDHI} acc_t;
	typedef enum logic [1:0] {FIN_NONE, FIN_S16, FIN_S25} fin_t;
	typedef enum logic [2:0] {WR_NONE, WR_HOLD, WR_POS, WR_ACCEL, WR_RATE} wr_t;

	typedef struct packed {
		hold_t             hold;
		logic              jmp;
		logic [STEP_W-1:0] target;
		ld_t               ld;
		mul_t              mul;
		coef_t             coef;
		acc_t              acc;
		fin_t              fin;
		wr_t               wr;
		logic              out_load;
	} ctl_t;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c.hold     = HOLD_NONE;
		c.jmp      = 1'b0;
		c.target   = STEP_FIRST;
		c.ld       = LD_NONE;
		c.mul      = MUL_NONE;
		c.coef     = COEF_TS;
		c.acc      = ACC_NONE;
		c.fin      = FIN_NONE;
		c.wr       = WR_NONE;
		c.out_load = 1'b0;
		unique case (step)
			5'd0: c.hold = HOLD_IN;
			5'd1: c.ld = LD_LIM;
			5'd2: begin
				c.mul  = MUL_LO;
				c.coef = COEF_DC;
			end
			5'd3: begin
				c.mul  = MUL_HI;
				c.coef = COEF_DC;
				c.acc  = ACC_LOAD;
				c.ld   = LD_RSUM;
			end
			5'd4: begin
				c.mul  = MUL_LO;
				c.coef = COEF_TS;
				c.acc  = ACC_ADDHI;
			end
			5'd5: begin
				c.mul  = MUL_HI;
				c.coef = COEF_TS;
				c.acc  = ACC_LOAD;
				c.fin  = FIN_S16;
			end
			5'd6: begin
				c.acc = ACC_ADDHI;
				c.wr  = WR_HOLD;
			end
			5'd7: c.fin = FIN_S25;
			5'd8: c.wr = WR_POS;
			5'd9: c.ld = LD_ERR;
			5'd10: begin
				c.mul  = MUL_LO;
				c.coef = COEF_WN;
			end
			5'd11: begin
				c.mul  = MUL_HI;
				c.coef = COEF_WN;
				c.acc  = ACC_LOAD;
			end
			5'd12: c.acc = ACC_ADDHI;
			5'd13: c.fin = FIN_S16;
			5'd14: c.wr = WR_ACCEL;
			5'd15: c.ld = LD_ASUM;
			5'd16: begin
				c.mul  = MUL_LO;
				c.coef = COEF_TS;
			end
			5'd17: begin
				c.mul  = MUL_HI;
				c.coef = COEF_TS;
				c.acc  = ACC_LOAD;
			end
			5'd18: c.acc = ACC_ADDHI;
			5'd19: c.fin = FIN_S25;
			5'd20: c.wr = WR_RATE;
			5'd21: begin
				c.out_load = 1'b1;
				c.hold     = HOLD_OUT;
				c.jmp      = 1'b1;
				c.target   = STEP_FIRST;
			end
			default: begin
				c.jmp    = 1'b1;
				c.target = STEP_FIRST;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/soas_seq.sv -----
// ----------------------------------------------------------------------------
// soas_seq
// Step counter and microcode read-out with hold and jump control.
// ----------------------------------------------------------------------------
module soas_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_free,
	output soas_pkg::ctl_t  ctl
);

	logic [soas_pkg::STEP_W-1:0] step_q;
	logic [soas_pkg::STEP_W-1:0] step_d;
	logic                        stall;

	assign ctl = soas_pkg::ucode(step_q);

	always_comb begin
		unique case (ctl.hold)
			soas_pkg::HOLD_IN:  stall = !in_fire;
			soas_pkg::HOLD_OUT: stall = !out_free;
			default:            stall = 1'b0;
		endcase
	end

	always_comb begin
		priority if (stall) begin
			step_d = step_q;
		end else if (ctl.jmp) begin
			step_d = ctl.target;
		end else begin
			step_d = step_q + soas_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= soas_pkg::STEP_FIRST;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ----- rtl/core/soas_dp.sv -----
// ----------------------------------------------------------------------------
// soas_dp
// Actuator datapath: state registers, operand loader, shared multiplier,
// product accumulator, scale-and-saturate stage and state update.
// ----------------------------------------------------------------------------
module soas_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  soas_pkg::ctl_t                     ctl,
	input  soas_pkg::cfg_t                     cfg,
	input  logic                               in_fire,
	input  logic signed [soas_pkg::WORD_W-1:0] fin_command,
	output logic signed [soas_pkg::WORD_W-1:0] fin_deflection
);

	localparam int unsigned SW = soas_pkg::STATE_W;
	localparam int unsigned MW = soas_pkg::MAG_W;
	localparam int unsigned AW = soas_pkg::ACC_W;
	localparam int unsigned PW = soas_pkg::PRD_W;
	localparam int unsigned XW = soas_pkg::MUL_A_W;
	localparam int unsigned CW = soas_pkg::COEF_W;

	logic signed [SW-1:0] pos_q, lrp_q, rate_q, accp_q;
	logic signed [SW-1:0] lim_q, res_q, hld_q, accel_q;
	logic signed [soas_pkg::WORD_W-1:0] cmd_q;
	logic [MW-1:0]        mag_q;
	logic                 neg_q, prd_neg_q, acc_neg_q;
	logic [PW-1:0]        prd_q;
	logic [AW-1:0]        acc_q;

	logic signed [MW-1:0] ld_v;
	logic [XW-1:0]        mul_a;
	logic [CW-1:0]        mul_b;
	logic [AW-1:0]        shf, cap, qv;
	logic signed [SW-1:0] res_d;
	logic [MW-1:0]        pos_neg;
	logic [soas_pkg::WORD_W-1:0] pos_mag;

	function automatic logic signed [SW-1:0] clamp_mag(input logic signed [MW-1:0] v,
			input logic [CW-1:0] lim);
		logic signed [MW-1:0] hi, lo;
		logic signed [SW-1:0] r;
		hi = signed'({2'b00, lim, 16'h0000});
		lo = -hi;
		if (v > hi) begin
			r = hi[SW-1:0];
		end else if (v < lo) begin
			r = lo[SW-1:0];
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SW-1:0] sat48(input logic signed [MW-1:0] v);
		logic signed [SW-1:0] r;
		if (v[MW-1] != v[MW-2]) begin
			r = v[MW-1] ? signed'(soas_pkg::MIN48_MAG) : signed'(soas_pkg::MAX48_MAG);
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [MW-1:0] sx(input logic signed [SW-1:0] v);
		return MW'(v);
	endfunction

	always_comb begin
		unique case (ctl.ld)
			soas_pkg::LD_LIM:  ld_v = sx(lim_q);
			soas_pkg::LD_RSUM: ld_v = sx(lim_q) + sx(lrp_q);
			soas_pkg::LD_ERR:  ld_v = sx(signed'({cmd_q, 16'h0000})) - sx(pos_q);
			soas_pkg::LD_ASUM: ld_v = sx(accel_q) + sx(accp_q);
			default:           ld_v = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.coef)
			soas_pkg::COEF_WN: mul_b = cfg.wn_squared;
			soas_pkg::COEF_DC: mul_b = cfg.damping_coeff;
			default:           mul_b = CW'(cfg.time_step);
		endcase
		mul_a = (ctl.mul == soas_pkg::MUL_HI) ? XW'(mag_q[MW-1:XW]) : mag_q[XW-1:0];
	end

	always_comb begin
		shf   = (ctl.fin == soas_pkg::FIN_S25) ? (acc_q >> 25) : (acc_q >> 16);
		cap   = acc_neg_q ? AW'(soas_pkg::MIN48_MAG) : AW'(soas_pkg::MAX48_MAG);
		qv    = (shf > cap) ? cap : shf;
		res_d = acc_neg_q ? signed'(SW'(0) - qv[SW-1:0]) : signed'(qv[SW-1:0]);
	end

	always_comb begin
		pos_neg = MW'(0) - MW'(pos_q);
		pos_mag = pos_neg[SW-1:16];
		fin_deflection = pos_q[SW-1] ? signed'(soas_pkg::WORD_W'(0) - pos_mag)
			: signed'(pos_q[SW-1:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lrp_q  <= '0;
			rate_q <= '0;
			accp_q <= '0;
		end else begin
			unique case (ctl.wr)
				soas_pkg::WR_POS: pos_q <= clamp_mag(sx(pos_q) + sx(res_q),
					cfg.deflection_limit);
				soas_pkg::WR_RATE: begin
					rate_q <= sat48(sx(rate_q) + sx(res_q));
					accp_q <= accel_q;
					lrp_q  <= lim_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= fin_command;
			lim_q <= clamp_mag(sx(rate_q), cfg.rate_limit);
		end
		if (ctl.ld != soas_pkg::LD_NONE) begin
			neg_q <= ld_v[MW-1];
			mag_q <= ld_v[MW-1] ? (MW'(0) - MW'(ld_v)) : MW'(ld_v);
		end
		if (ctl.mul != soas_pkg::MUL_NONE) begin
			prd_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (ctl.mul == soas_pkg::MUL_LO) begin
			prd_neg_q <= neg_q;
		end
		unique case (ctl.acc)
			soas_pkg::ACC_LOAD: begin
				acc_q     <= AW'(prd_q);
				acc_neg_q <= prd_neg_q;
			end
			soas_pkg::ACC_ADDHI: acc_q <= acc_q + {prd_q[AW-XW-1:0], XW'(0)};
			default: ;
		endcase
		if (ctl.fin != soas_pkg::FIN_NONE) begin
			res_q <= res_d;
		end
		if (ctl.wr == soas_pkg::WR_HOLD) begin
			hld_q <= res_q;
		end
		if (ctl.wr == soas_pkg::WR_ACCEL) begin
			accel_q <= sat48(sx(res_q) - sx(hld_q));
		end
	end

endmodule

// ----- rtl/core/second_order_actuator_step_unit.sv -----
// ----------------------------------------------------------------------------
// second_order_actuator_step_unit
// Second-order fin actuator with rate and position limits, one tick per word.
// ----------------------------------------------------------------------------
// Each input word on s_axis is one simulation tick carrying the fin command
// (signed Q16.16). The unit answers with one output word on m_axis holding the
// limited fin deflection (signed Q16.16). The cfg channel writes the five
// parameter registers (index 0..4); cfg_ready is always high and writes to
// other indexes are dropped. Write them only while no tick is in flight.
// A tick runs through a 22-step microcode program on one shared 32x31
// multiplier: four scaled products of two partial products each, plus loads
// and state updates. The output word is loaded at the last step, and the next
// input word is taken only once the program is back at its first step. The
// output register holds its word while m_axis_tready is low; the program
// waits at its last step until that word leaves, then accepts the next tick.
// Reset clears the actuator state to zero, loads the default parameters and
// puts the program at its first step; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module second_order_actuator_step_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [soas_pkg::WORD_W-1:0]           s_axis_tdata,  // [31:0] fin_command
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [soas_pkg::WORD_W-1:0]           m_axis_tdata,  // [31:0] fin_deflection
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [soas_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [soas_pkg::WORD_W-1:0]           cfg_data
);

	soas_pkg::ctl_t ctl;
	soas_pkg::cfg_t cfg_q;
	logic           in_fire;
	logic           out_free;
	logic           out_valid_q;
	logic [soas_pkg::WORD_W-1:0] out_data_q;
	logic signed [soas_pkg::WORD_W-1:0] defl;

	assign s_axis_tready = (ctl.hold == soas_pkg::HOLD_IN);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

	soas_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctl      (ctl)
	);

	soas_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cfg            (cfg_q),
		.in_fire        (in_fire),
		.fin_command    (signed'(s_axis_tdata)),
		.fin_deflection (defl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deflection_limit <= soas_pkg::RST_DEFL_LIMIT;
			cfg_q.rate_limit       <= soas_pkg::RST_RATE_LIMIT;
			cfg_q.wn_squared       <= soas_pkg::RST_WN_SQUARED;
			cfg_q.damping_coeff    <= soas_pkg::RST_DAMPING;
			cfg_q.time_step        <= soas_pkg::RST_TIME_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				soas_pkg::CFG_DEFL_LIMIT: cfg_q.deflection_limit <= cfg_data[30:0];
				soas_pkg::CFG_RATE_LIMIT: cfg_q.rate_limit       <= cfg_data[30:0];
				soas_pkg::CFG_WN_SQUARED: cfg_q.wn_squared       <= cfg_data[30:0];
				soas_pkg::CFG_DAMPING:    cfg_q.damping_coeff    <= cfg_data[30:0];
				soas_pkg::CFG_TIME_STEP:  cfg_q.time_step        <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load && out_free) begin
			out_data_q <= defl;
		end
	end

	a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("input taken again right after a tick was accepted");

	a_wait_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.hold == soas_pkg::HOLD_OUT) && !out_free |=> (ctl.hold == soas_pkg::HOLD_OUT))
		else $error("program left its last step while the output word was stalled");

	a_result_presented: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load && out_free |=> m_axis_tvalid)
		else $error("finished tick did not reach the output register");

endmodule

// ----- tb/tb_second_order_actuator_step_unit.sv -----
// ----------------------------------------------------------------------------
// tb_second_order_actuator_step_unit
// Self-checking bench for the fin actuator step unit.
// ----------------------------------------------------------------------------
// Sends fin command words and predicts each deflection word with a bit-exact
// model of the actuator in Q16.32 state arithmetic. Every output word is
// checked in order. Covers directed corners (command extremes, zero and full
// scale limits, saturation, dropped register indexes) and randomized parameter
// sets with held step commands, random gaps on both streams, a long output
// stall and a gap-free stretch.
// ----------------------------------------------------------------------------
module tb_second_order_actuator_step_unit;
	import soas_pkg::*;

	localparam longint SAT_HI = 64'sd140737488355327;
	localparam longint SAT_LO = -64'sd140737488355328;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [WORD_W-1:0]    s_axis_tdata  = '0;  // [31:0] fin_command
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [WORD_W-1:0]    m_axis_tdata;        // [31:0] fin_deflection
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [WORD_W-1:0]    cfg_data      = '0;

	cfg_t model_cfg = '{
		deflection_limit: RST_DEFL_LIMIT,
		rate_limit:       RST_RATE_LIMIT,
		wn_squared:       RST_WN_SQUARED,
		damping_coeff:    RST_DAMPING,
		time_step:        RST_TIME_STEP
	};
	longint pos_q           = 0;
	longint lim_rate_prev_q = 0;
	longint rate_q          = 0;
	longint accel_prev_q    = 0;

	logic [WORD_W-1:0] pending_deflection[$];
	int n_errors        = 0;
	int ticks_sent      = 0;
	int words_checked   = 0;
	int settings_loaded = 0;
	int hold_budget     = 0;
	bit no_idle         = 1'b0;

	second_order_actuator_step_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint sat48(input longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// sign(a) * trunc(|a| * b / 2^sh), saturated to 48 bits
	function automatic longint scaled_product(input longint a, input logic [31:0] b,
			input int unsigned sh);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] q;
		mag  = (a < 0) ? 64'(-a) : 64'(a);
		prod = {64'd0, mag} * {96'd0, b};
		q    = prod >> sh;
		if (a < 0) begin
			if (q > 128'h8000_0000_0000) q = 128'h8000_0000_0000;
			return -longint'(q[63:0]);
		end
		if (q > 128'h7FFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF;
		return longint'(q[63:0]);
	endfunction

	function automatic longint clamp_mag(input longint v, input logic [COEF_W-1:0] lim);
		longint bound;
		bound = longint'({33'd0, lim}) * 65536;
		if (v > bound) return bound;
		if (v < -bound) return -bound;
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] advance_actuator(input logic [WORD_W-1:0] cmd);
		longint cmd_q, lim_rate, err, accel, mag;
		logic [63:0] res;
		cmd_q    = longint'($signed(cmd));
		lim_rate = clamp_mag(rate_q, model_cfg.rate_limit);
		pos_q    = sat48(pos_q + scaled_product(lim_rate + lim_rate_prev_q,
			{8'd0, model_cfg.time_step}, 25));
		pos_q    = clamp_mag(pos_q, model_cfg.deflection_limit);
		lim_rate_prev_q = lim_rate;
		err      = cmd_q * 65536 - pos_q;
		accel    = sat48(scaled_product(err, {1'b0, model_cfg.wn_squared}, 16)
			- scaled_product(lim_rate, {1'b0, model_cfg.damping_coeff}, 16));
		rate_q   = sat48(rate_q + scaled_product(accel + accel_prev_q,
			{8'd0, model_cfg.time_step}, 25));
		accel_prev_q = accel;
		if (pos_q < 0) begin
			mag = (-pos_q) >>> 16;
			res = 64'(-mag);
		end else begin
			res = 64'(pos_q >>> 16);
		end
		return res[WORD_W-1:0];
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef(input int unsigned typical);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return COEF_W'($urandom);
			default: return COEF_W'($urandom_range(typical, 1));
		endcase
	endfunction

	function automatic logic [TS_W-1:0] pick_step();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return TS_W'($urandom);
			default: return TS_W'($urandom_range(1 << 20, 1));
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		s.deflection_limit = pick_coef(40 << 16);
		s.rate_limit       = pick_coef(400 << 16);
		s.wn_squared       = pick_coef(4000 << 16);
		s.damping_coeff    = pick_coef(200 << 16);
		s.time_step        = pick_step();
		return s;
	endfunction

	function automatic logic [WORD_W-1:0] pick_command(input logic [COEF_W-1:0] lim);
		longint span;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return $urandom;
		if (r < 14) return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
		span = longint'(lim) * 2 + 65536;
		if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
		return WORD_W'(longint'($urandom_range(32'(span * 2), 0)) - span);
	endfunction

	// output side: check every word, stall at random or for a requested stretch
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_deflection.size() == 0) begin
				$display("%0t: unexpected fin_deflection word, expected none actual %h",
					$time, m_axis_tdata);
				n_errors++;
			end else begin
				want = pending_deflection.pop_front();
				words_checked++;
				if (m_axis_tdata !== want) begin
					$display("%0t: fin_deflection mismatch, expected %h actual %h",
						$time, want, m_axis_tdata);
					n_errors++;
				end
			end
		end
		if (hold_budget > 0) begin
			m_axis_tready <= 1'b0;
			hold_budget--;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
		end
	end

	task automatic send_tick(input logic [WORD_W-1:0] cmd);
		while (!no_idle && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_deflection.push_back(advance_actuator(cmd));
		ticks_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_deflection.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_DEFL_LIMIT: model_cfg.deflection_limit = data[COEF_W-1:0];
			CFG_RATE_LIMIT: model_cfg.rate_limit       = data[COEF_W-1:0];
			CFG_WN_SQUARED: model_cfg.wn_squared       = data[COEF_W-1:0];
			CFG_DAMPING:    model_cfg.damping_coeff    = data[COEF_W-1:0];
			CFG_TIME_STEP:  model_cfg.time_step        = data[TS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// junk in the unused upper bits must be dropped
	task automatic load_settings(input cfg_t s);
		wait_drained();
		cfg_write(CFG_DEFL_LIMIT, {1'($urandom), s.deflection_limit});
		cfg_write(CFG_RATE_LIMIT, {1'($urandom), s.rate_limit});
		cfg_write(CFG_WN_SQUARED, {1'($urandom), s.wn_squared});
		cfg_write(CFG_DAMPING,    {1'($urandom), s.damping_coeff});
		cfg_write(CFG_TIME_STEP,  {8'($urandom), s.time_step});
		cfg_release();
		settings_loaded++;
	endtask

	task automatic test_reset_settings();
		send_tick(32'h0000_0000);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		send_tick(32'h0000_0001);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h000A_0000);
		send_tick(32'hFFF6_0000);
		send_tick(32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_zero_limits();
		cfg_t s;
		s = model_cfg;
		s.deflection_limit = '0;
		s.rate_limit       = '0;
		load_settings(s);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		send_tick(32'h0001_0000);
		s.deflection_limit = '1;
		load_settings(s);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		wait_drained();
	endtask

	task automatic test_saturation();
		cfg_t s;
		s = '{'1, '1, '1, '0, '1};
		load_settings(s);
		repeat (3) begin
			send_tick(32'h7FFF_FFFF);
			send_tick(32'h8000_0000);
		end
		s.time_step = '0;
		load_settings(s);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		s.time_step  = '1;
		s.wn_squared = '0;
		s.damping_coeff = '1;
		load_settings(s);
		send_tick(32'h0000_0000);
		send_tick(32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_unused_indexes();
		wait_drained();
		for (int i = CFG_TIME_STEP + 1; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), $urandom);
		cfg_release();
		send_tick(32'h0003_0000);
		send_tick(32'hFFFD_0000);
		wait_drained();
	endtask

	task automatic test_random_settings();
		cfg_t s;
		int count;
		logic [WORD_W-1:0] cmd;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: s = '{RST_DEFL_LIMIT, RST_RATE_LIMIT, RST_WN_SQUARED, RST_DAMPING,
					RST_TIME_STEP};
				1: s = '{'0, '0, '0, '0, '0};
				2: s = '{'1, '1, '1, '1, '1};
				default: s = random_settings();
			endcase
			load_settings(s);
			count = 0;
			// hold a step command for a run of ticks, with some noisy runs
			while (count < 50) begin
				cmd = pick_command(s.deflection_limit);
				repeat ($urandom_range(20, 1)) begin
					if ($urandom_range(9) == 0) send_tick(pick_command(s.deflection_limit));
					else send_tick(cmd);
					count++;
				end
			end
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		hold_budget = 300;
		repeat (6) send_tick(pick_command(model_cfg.deflection_limit));
		wait_drained();
	endtask

	task automatic test_streaming_no_idle();
		load_settings(random_settings());
		no_idle = 1'b1;
		repeat (60) send_tick(pick_command(model_cfg.deflection_limit));
		wait_drained();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_zero_limits();
		test_saturation();
		test_unused_indexes();
		test_random_settings();
		test_output_backpressure();
		test_streaming_no_idle();
		wait_drained();
		repeat (40) @(posedge clk);
		$display("Covered %0d command ticks, %0d deflection words checked, %0d parameter sets,",
			ticks_sent, words_checked, settings_loaded);
		$display("with limit corners, saturation, output back-pressure and gap-free streaming.");
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors", n_errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d deflection words outstanding", pending_deflection.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
